// File: rtl/apn_pkg.sv
`timescale 1ns / 1ps

package apn_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 17;
    localparam int TARGET_W = 15;
    localparam int GAIN_W   = 32;
    localparam int QUO_W    = 31;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int FRAC_W   = 16;

    // Reset values and unity gain in Q16.16.
    localparam logic [TARGET_W-1:0] TARGET_RESET = 15'h7FFF;
    localparam logic [GAIN_W-1:0]   UNITY_GAIN   = 32'h0001_0000;

    // Default queue depths.
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int RESULT_DEPTH_DEF = 4;

    // Function codes.
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_SCALE   = 1'b1;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic             is_scale;
        logic             first;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } item_t;

endpackage

// File: rtl/audio_peak_normaliser_top.sv
`timescale 1ns / 1ps

// Two-pass peak normalizer for signed Q1.15 audio samples.
// Input channel: a word is taken when push is high and full is low. func
// selects measure (track the peak |sample|, first clears it beforehand) or
// scale (emit sample times gain, truncated and saturated to +/- target).
// Result channel: while empty is low, scaled_sample shows the oldest word;
// it is taken when pop is high. Only scale words produce results.
// Configuration: cfg_wr_en writes cfg_wr_data into the target peak, to be
// used while the block is idle.
// Throughput: one word per cycle, while scale words find room in the result
// queue. The first scale word after any measure computes the gain with a
// restoring divider, one quotient bit per cycle, holding the back end until
// the gain is ready; a zero peak skips the divide and gives unity gain.
// Path: a scale word passes the input queue, the multiply stage register
// and the result queue before it appears on the result ports.
// Reset: target returns to 32767, peak to zero, gain to unity, all queues
// empty. When pop stays low the result queue fills, the back end stops
// issuing, the input queue fills and full rises; nothing is dropped.
module audio_peak_normaliser_top
    import apn_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [TARGET_W-1:0]        cfg_wr_data,
    input  logic                       push,
    output logic                       full,
    input  logic                       func,
    input  logic                       first,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] scaled_sample
);

    item_t item_head;
    logic  item_empty;
    logic  item_pop;

    // Front end: classify and queue incoming words.
    apn_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .first        (first),
        .sample_value (sample_value),
        .item_pop     (item_pop),
        .item_head    (item_head),
        .item_empty   (item_empty)
    );

    // Back end: peak tracking, gain divide, scaling and result queue.
    apn_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .item_head     (item_head),
        .item_empty    (item_empty),
        .item_pop      (item_pop),
        .empty         (empty),
        .pop           (pop),
        .scaled_sample (scaled_sample)
    );

endmodule

// File: rtl/apn_fifo.sv
`timescale 1ns / 1ps

module apn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       is_full,
    output logic                       is_empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign is_full  = (cnt_reg == FULL_CNT);
    assign is_empty = (cnt_reg == '0);
    assign level    = cnt_reg;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;

    // Pointer and count update with wrap at the last entry.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/apn_front.sv
`timescale 1ns / 1ps

module apn_front
    import apn_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       func,
    input  logic                       first,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       item_pop,
    output item_t                      item_head,
    output logic                       item_empty
);

    localparam int ITEM_W = $bits(item_t);

    logic [SAMPLE_W-1:0]            raw;
    item_t                          item_in;
    logic [ITEM_W-1:0]              head_bits;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

    // Split the sample into sign and magnitude; the most negative value
    // keeps its full magnitude of 32768 as an unsigned value.
    assign raw = $unsigned(sample_value);

    always_comb
    begin
        item_in.is_scale = (func == FUNC_SCALE);
        item_in.first    = first;
        item_in.neg      = raw[SAMPLE_W-1];
        if (raw[SAMPLE_W-1])
        begin
            item_in.mag = (MAG_W'(1) << SAMPLE_W) - {1'b0, raw};
        end
        else
        begin
            item_in.mag = {1'b0, raw};
        end
    end

    // Queue between the accepting side and the processing side.
    apn_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (item_in),
        .rd_en    (item_pop),
        .rd_data  (head_bits),
        .is_full  (full),
        .is_empty (item_empty),
        .level    (q_level)
    );

    assign item_head = item_t'(head_bits);

    // The level is not needed on this side beyond the full flag.
    logic unused_level;
    assign unused_level = ^q_level;

endmodule

// File: rtl/apn_back.sv
`timescale 1ns / 1ps

module apn_back
    import apn_pkg::*;
#(
    parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [TARGET_W-1:0]        cfg_wr_data,
    input  item_t                      item_head,
    input  logic                       item_empty,
    output logic                       item_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] scaled_sample
);

    localparam int RCNT_W = $clog2(RESULT_DEPTH + 1);
    localparam int DCNT_W = $clog2(QUO_W);
    localparam int REM_W  = MAG_W - 1;
    localparam int HI_W   = PROD_W - FRAC_W;
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(QUO_W - 1);
    localparam logic [RCNT_W:0]   RES_SLOTS = (RCNT_W + 1)'(RESULT_DEPTH);

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [TARGET_W-1:0] target_reg;
    logic [MAG_W-1:0]    peak_reg, peak_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic                ready_reg, ready_next;

    // Divider registers: dq holds dividend bits shifting out and
    // quotient bits shifting in.
    logic [QUO_W-1:0]    dq_reg, dq_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [MAG_W-1:0]    rem_sh;
    logic                q_bit;

    // Multiply stage.
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_neg_reg;
    logic [HI_W-1:0]     s1_prod_reg;
    logic [PROD_W-1:0]   prod_full;
    logic                issue;

    // Result queue side.
    logic [RCNT_W-1:0]   res_level;
    logic                res_full;
    logic [TARGET_W-1:0] sat_mag;
    logic [SAMPLE_W-1:0] res_word;
    logic [SAMPLE_W-1:0] res_head;
    logic                has_room;

    // Room for one more word counting the one in the multiply stage.
    assign has_room = ({1'b0, res_level} + (RCNT_W + 1)'(s1_valid_reg)) < RES_SLOTS;

    // One restoring divide step.
    assign rem_sh = {rem_reg, dq_reg[QUO_W-1]};
    assign q_bit  = (rem_sh >= peak_reg);

    // Control: measure, gain setup, divide and issue of scale words.
    always_comb
    begin
        state_next = state_reg;
        peak_next  = peak_reg;
        gain_next  = gain_reg;
        ready_next = ready_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        item_pop   = 1'b0;
        issue      = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (!item_empty)
                begin
                    if (!item_head.is_scale)
                    begin
                        item_pop   = 1'b1;
                        ready_next = 1'b0;
                        if (item_head.first || (item_head.mag > peak_reg))
                        begin
                            peak_next = item_head.mag;
                        end
                    end
                    else if (!ready_reg)
                    begin
                        if (peak_reg == '0)
                        begin
                            gain_next  = UNITY_GAIN;
                            ready_next = 1'b1;
                        end
                        else
                        begin
                            dq_next    = {target_reg, FRAC_W'(0)};
                            rem_next   = '0;
                            dcnt_next  = '0;
                            state_next = ST_DIV;
                        end
                    end
                    else if (has_room)
                    begin
                        item_pop = 1'b1;
                        issue    = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = q_bit ? REM_W'(rem_sh - peak_reg) : rem_sh[REM_W-1:0];
                dq_next   = {dq_reg[QUO_W-2:0], q_bit};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_LAST)
                begin
                    gain_next  = {{(GAIN_W - QUO_W){1'b0}}, dq_next};
                    ready_next = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign s1_valid_next = issue;
    assign prod_full     = PROD_W'(item_head.mag) * PROD_W'(gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            target_reg   <= TARGET_RESET;
            peak_reg     <= '0;
            gain_reg     <= UNITY_GAIN;
            ready_reg    <= 1'b0;
            dcnt_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            peak_reg     <= peak_next;
            gain_reg     <= gain_next;
            ready_reg    <= ready_next;
            dcnt_reg     <= dcnt_next;
            s1_valid_reg <= s1_valid_next;
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (issue)
        begin
            s1_prod_reg <= prod_full[PROD_W-1:FRAC_W];
            s1_neg_reg  <= item_head.neg;
        end
    end

    // Saturate to the target magnitude and restore the sign.
    always_comb
    begin
        if (s1_prod_reg > HI_W'(target_reg))
        begin
            sat_mag = target_reg;
        end
        else
        begin
            sat_mag = s1_prod_reg[TARGET_W-1:0];
        end
        if (s1_neg_reg)
        begin
            res_word = SAMPLE_W'(0) - {1'b0, sat_mag};
        end
        else
        begin
            res_word = {1'b0, sat_mag};
        end
    end

    apn_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s1_valid_reg),
        .wr_data  (res_word),
        .rd_en    (pop),
        .rd_data  (res_head),
        .is_full  (res_full),
        .is_empty (empty),
        .level    (res_level)
    );

    assign scaled_sample = $signed(res_head);

    // Space is tracked by the level; the full flag is redundant here.
    logic unused_full;
    assign unused_full = res_full;

endmodule
